[hdl/gradient_nonmax_suppression_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the gradient non-maximum suppression block
// Concurrent property wrappers shared by the verification checker.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NONMAX_SUPPRESSION_DEFINES_SVH
`define GRADIENT_NONMAX_SUPPRESSION_DEFINES_SVH

// Same-cycle implication, inactive while reset is asserted
`define GNMS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gnms property violated");

// Next-cycle implication, inactive while reset is asserted
`define GNMS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gnms property violated");

// Next-cycle implication that also covers the reset itself
`define GNMS_ASSERT_RESET(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("gnms reset property violated");

`endif

[hdl/gnms_pkg.sv]
// ----------------------------------------------------------------------------
// gnms_pkg
// Shared constants, register codes and types for gradient non-max suppression.
// ----------------------------------------------------------------------------
package gnms_pkg;

    // Default build sizes
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    // Frame geometry
    localparam int ROW_BITS    = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_DIM     = 3;

    // Configuration registers
    localparam int CFG_W_BITS    = 11;
    localparam int CFG_H_BITS    = 13;
    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 1;
    localparam int WIDTH_RESET   = 640;
    localparam int HEIGHT_RESET  = 480;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'b1;

    // 3x3 window positions, row major, top-left first
    localparam int WIN_SIZE = 9;
    localparam int WIN_NW   = 0;
    localparam int WIN_N    = 1;
    localparam int WIN_NE   = 2;
    localparam int WIN_W    = 3;
    localparam int WIN_C    = 4;
    localparam int WIN_E    = 5;
    localparam int WIN_SW   = 6;
    localparam int WIN_S    = 7;
    localparam int WIN_SE   = 8;

    // Forward control between the window front end and the decision pipe
    typedef struct packed {
        logic valid;
        logic border;
    } gnms_tag_t;

endpackage

[hdl/gnms_line_ram.sv]
// ----------------------------------------------------------------------------
// gnms_line_ram
// Simple dual-port line memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gnms_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/gnms_front.sv]
// ----------------------------------------------------------------------------
// gnms_front
// Raster counters, line memory read-modify-write and the 3x3 magnitude window.
// ----------------------------------------------------------------------------
module gnms_front
    import gnms_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int COL_BITS   = $clog2(MAX_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Frame geometry
    input  logic [CFG_W_BITS-1:0]         cfg_width,
    input  logic [CFG_H_BITS-1:0]         cfg_height,
    // Incoming pixels
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        in_mag,
    input  logic signed [SAMPLE_BITS-1:0] in_gx,
    input  logic signed [SAMPLE_BITS-1:0] in_gy,
    // Centre pixels towards the decision pipe
    output gnms_tag_t                     out_tag,
    input  logic                          out_ready,
    output logic [SAMPLE_BITS-1:0]        out_win [WIN_SIZE],
    output logic signed [SAMPLE_BITS-1:0] out_gx,
    output logic signed [SAMPLE_BITS-1:0] out_gy,
    output logic [ROW_BITS-1:0]           out_row,
    output logic [COL_BITS-1:0]           out_col
);

    localparam int WC_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int WX_BITS  = (WC_BITS > CFG_W_BITS) ? WC_BITS : CFG_W_BITS;
    localparam int SB       = SAMPLE_BITS;
    localparam int WORD_W   = 4 * SAMPLE_BITS;

    // Effective geometry
    logic [WX_BITS-1:0]     width_x;
    logic [WC_BITS-1:0]     width_eff;
    logic [HEIGHT_BITS-1:0] height_eff;

    // Raster position of the next pixel
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [COL_BITS:0]      col_p1;
    logic [HEIGHT_BITS-1:0] row_p1;
    logic                   emit_now;
    logic                   border_now;

    // Stage 1: pixel waiting for its line memory word
    logic                   s1_valid_reg;
    logic [SB-1:0]          s1_mag_reg;
    logic [SB-1:0]          s1_gx_reg;
    logic [SB-1:0]          s1_gy_reg;
    logic [COL_BITS-1:0]    s1_addr_reg;
    logic                   s1_emit_reg;
    logic                   s1_border_reg;
    logic [ROW_BITS-1:0]    s1_row_reg;
    logic [COL_BITS-1:0]    s1_col_reg;

    // Stage 2: window settled around the centre pixel
    logic                   s2_valid_reg;
    logic                   s2_emit_reg;
    logic                   s2_border_reg;
    logic [ROW_BITS-1:0]    s2_row_reg;
    logic [COL_BITS-1:0]    s2_col_reg;
    logic [SB-1:0]          s2_gx_reg;
    logic [SB-1:0]          s2_gy_reg;

    logic [SB-1:0]          gx_dly_reg;
    logic [SB-1:0]          gy_dly_reg;
    logic [SB-1:0]          win_reg [WIN_SIZE];

    // Handshake
    logic                   en1, en2;
    logic                   accept;
    logic                   s1_move;

    // Line memory
    logic [WORD_W-1:0]      rd_word;
    logic [WORD_W-1:0]      wr_word;
    logic [SB-1:0]          rd_older;
    logic [SB-1:0]          rd_newer;
    logic [SB-1:0]          rd_gx;
    logic [SB-1:0]          rd_gy;

    // Clamp the configured geometry
    always_comb begin
        width_x = WX_BITS'(cfg_width);
        if (width_x < WX_BITS'(MIN_DIM)) begin
            width_eff = WC_BITS'(MIN_DIM);
        end else if (width_x > WX_BITS'(MAX_WIDTH)) begin
            width_eff = WC_BITS'(MAX_WIDTH);
        end else begin
            width_eff = WC_BITS'(width_x);
        end
        if (cfg_height < HEIGHT_BITS'(MIN_DIM)) begin
            height_eff = HEIGHT_BITS'(MIN_DIM);
        end else if (cfg_height > HEIGHT_BITS'(MAX_HEIGHT)) begin
            height_eff = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            height_eff = cfg_height;
        end
    end

    // Advance the raster position and classify the centre pixel
    always_comb begin
        col_p1     = {1'b0, col_reg} + 1'b1;
        row_p1     = {1'b0, row_reg} + 1'b1;
        emit_now   = (row_reg != '0) && (col_reg != '0)
                     && (HEIGHT_BITS'(row_reg) < height_eff)
                     && ((COL_BITS + 1)'(col_reg) < (COL_BITS + 1)'(width_eff));
        border_now = (row_reg == ROW_BITS'(1)) || (col_reg == COL_BITS'(1));
        if (col_p1 >= (COL_BITS + 1)'(width_eff)) begin
            col_next = '0;
            row_next = (row_p1 >= height_eff) ? '0 : ROW_BITS'(row_p1);
        end else begin
            col_next = COL_BITS'(col_p1);
            row_next = row_reg;
        end
    end

    // Pipeline flow: stage 2 drops pixels that give no result
    assign en2      = !s2_valid_reg || !s2_emit_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign accept   = in_valid && en1;
    assign s1_move  = s1_valid_reg && en2;

    // Line memory word: older magnitude, newer magnitude, gx, gy
    assign rd_older = rd_word[4*SB-1:3*SB];
    assign rd_newer = rd_word[3*SB-1:2*SB];
    assign rd_gx    = rd_word[2*SB-1:SB];
    assign rd_gy    = rd_word[SB-1:0];
    assign wr_word  = {rd_newer, s1_mag_reg, s1_gx_reg, s1_gy_reg};

    gnms_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (WORD_W)
    ) u_line_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_word),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_word)
    );

    // Control state: position, stage valids, window and gradient delay
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            gx_dly_reg   <= '0;
            gy_dly_reg   <= '0;
            for (int k = 0; k < WIN_SIZE; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (en1) begin
                s1_valid_reg <= in_valid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move) begin
                // shift the window left and load the new right column
                for (int k = 0; k < 3; k++) begin
                    win_reg[k*3]     <= win_reg[k*3 + 1];
                    win_reg[k*3 + 1] <= win_reg[k*3 + 2];
                end
                win_reg[WIN_NE] <= rd_older;
                win_reg[WIN_E]  <= rd_newer;
                win_reg[WIN_SE] <= s1_mag_reg;
                gx_dly_reg      <= rd_gx;
                gy_dly_reg      <= rd_gy;
            end
        end
    end

    // Payload of stages 1 and 2
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mag_reg    <= in_mag;
            s1_gx_reg     <= in_gx;
            s1_gy_reg     <= in_gy;
            s1_addr_reg   <= col_reg;
            s1_emit_reg   <= emit_now;
            s1_border_reg <= border_now;
            s1_row_reg    <= row_reg - 1'b1;
            s1_col_reg    <= col_reg - 1'b1;
        end
        if (s1_move) begin
            s2_emit_reg   <= s1_emit_reg;
            s2_border_reg <= s1_border_reg;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_gx_reg     <= gx_dly_reg;
            s2_gy_reg     <= gy_dly_reg;
        end
    end

    assign out_tag.valid  = s2_valid_reg && s2_emit_reg;
    assign out_tag.border = s2_border_reg;
    assign out_win        = win_reg;
    assign out_gx         = s2_gx_reg;
    assign out_gy         = s2_gy_reg;
    assign out_row        = s2_row_reg;
    assign out_col        = s2_col_reg;

endmodule

[hdl/gnms_decide.sv]
// ----------------------------------------------------------------------------
// gnms_decide
// Octant selection, cross-multiplied interpolation compare and result register.
// ----------------------------------------------------------------------------
module gnms_decide
    import gnms_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COL_BITS    = $clog2(DEF_MAX_WIDTH)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Centre pixels from the window front end
    input  gnms_tag_t                     in_tag,
    output logic                          in_ready,
    input  logic [SAMPLE_BITS-1:0]        in_win [WIN_SIZE],
    input  logic signed [SAMPLE_BITS-1:0] in_gx,
    input  logic signed [SAMPLE_BITS-1:0] in_gy,
    input  logic [ROW_BITS-1:0]           in_row,
    input  logic [COL_BITS-1:0]           in_col,
    // Results
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [SAMPLE_BITS-1:0]        res_value,
    output logic [ROW_BITS-1:0]           res_row,
    output logic [COL_BITS-1:0]           res_col
);

    localparam int SB = SAMPLE_BITS;
    localparam int PB = 2 * SAMPLE_BITS;

    // Octant selection
    logic          gx_neg, gy_neg;
    logic [SB:0]   sum_xy;
    logic [SB:0]   diff_yx;
    logic [SB-1:0] ax, ay;
    logic [SB-1:0] sel_major, sel_minor;
    logic [SB-1:0] sel_a1, sel_b1, sel_a2, sel_b2;
    logic [SB-1:0] sel_m;

    // Stage 3: operands
    logic          s3_valid_reg;
    logic [SB-1:0] s3_m_reg;
    logic [SB-1:0] s3_major_reg;
    logic [SB-1:0] s3_minor_reg;
    logic [SB-1:0] s3_span_reg;
    logic [SB-1:0] s3_a1_reg, s3_b1_reg, s3_a2_reg, s3_b2_reg;
    logic [ROW_BITS-1:0] s3_row_reg;
    logic [COL_BITS-1:0] s3_col_reg;

    // Stage 4: products
    logic          s4_valid_reg;
    logic [SB-1:0] s4_m_reg;
    logic [PB-1:0] s4_pm_reg;
    logic [PB-1:0] s4_pa1_reg, s4_pb1_reg, s4_pa2_reg, s4_pb2_reg;
    logic [ROW_BITS-1:0] s4_row_reg;
    logic [COL_BITS-1:0] s4_col_reg;

    // Result register
    logic          out_valid_reg;
    logic [SB-1:0] out_value_reg;
    logic [ROW_BITS-1:0] out_row_reg;
    logic [COL_BITS-1:0] out_col_reg;

    logic [PB:0]   interp1, interp2;
    logic          suppress;
    logic          en3, en4, en_out;

    // Flow control
    assign en_out   = !out_valid_reg || res_ready;
    assign en4      = !s4_valid_reg || en_out;
    assign en3      = !s3_valid_reg || en4;
    assign in_ready = en3;

    // Sort the gradient into its octant and pick the two neighbour pairs
    always_comb begin
        gx_neg  = in_gx[SB-1];
        gy_neg  = in_gy[SB-1];
        sum_xy  = {in_gx[SB-1], in_gx} + {in_gy[SB-1], in_gy};
        diff_yx = {in_gy[SB-1], in_gy} - {in_gx[SB-1], in_gx};
        ax      = gx_neg ? SB'(~in_gx + 1'b1) : in_gx;
        ay      = gy_neg ? SB'(~in_gy + 1'b1) : in_gy;
        sel_m   = in_tag.border ? '0 : in_win[WIN_C];
        if (!gx_neg) begin
            if (!gy_neg) begin
                if (in_gx >= in_gy) begin
                    sel_major = ax;             sel_minor = ay;
                    sel_a1 = in_win[WIN_E];     sel_b1 = in_win[WIN_SE];
                    sel_a2 = in_win[WIN_W];     sel_b2 = in_win[WIN_NW];
                end else begin
                    sel_major = ay;             sel_minor = ax;
                    sel_a1 = in_win[WIN_S];     sel_b1 = in_win[WIN_SE];
                    sel_a2 = in_win[WIN_N];     sel_b2 = in_win[WIN_NW];
                end
            end else begin
                if (!sum_xy[SB]) begin
                    sel_major = ax;             sel_minor = ay;
                    sel_a1 = in_win[WIN_E];     sel_b1 = in_win[WIN_NE];
                    sel_a2 = in_win[WIN_W];     sel_b2 = in_win[WIN_SW];
                end else begin
                    sel_major = ay;             sel_minor = ax;
                    sel_a1 = in_win[WIN_S];     sel_b1 = in_win[WIN_SW];
                    sel_a2 = in_win[WIN_N];     sel_b2 = in_win[WIN_NE];
                end
            end
        end else begin
            if (!gy_neg) begin
                if (!sum_xy[SB]) begin
                    sel_major = ay;             sel_minor = ax;
                    sel_a1 = in_win[WIN_S];     sel_b1 = in_win[WIN_SW];
                    sel_a2 = in_win[WIN_N];     sel_b2 = in_win[WIN_NE];
                end else begin
                    sel_major = ax;             sel_minor = ay;
                    sel_a1 = in_win[WIN_W];     sel_b1 = in_win[WIN_SW];
                    sel_a2 = in_win[WIN_E];     sel_b2 = in_win[WIN_NE];
                end
            end else begin
                if (!diff_yx[SB]) begin
                    sel_major = ax;             sel_minor = ay;
                    sel_a1 = in_win[WIN_W];     sel_b1 = in_win[WIN_NW];
                    sel_a2 = in_win[WIN_E];     sel_b2 = in_win[WIN_SE];
                end else begin
                    sel_major = ay;             sel_minor = ax;
                    sel_a1 = in_win[WIN_N];     sel_b1 = in_win[WIN_NW];
                    sel_a2 = in_win[WIN_S];     sel_b2 = in_win[WIN_SE];
                end
            end
        end
    end

    // Interpolated neighbours, scaled by major, against the scaled centre
    always_comb begin
        interp1  = {1'b0, s4_pa1_reg} + {1'b0, s4_pb1_reg};
        interp2  = {1'b0, s4_pa2_reg} + {1'b0, s4_pb2_reg};
        suppress = ({1'b0, s4_pm_reg} < interp1) || ({1'b0, s4_pm_reg} < interp2);
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (en3) begin
                s3_valid_reg <= in_tag.valid;
            end
            if (en4) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en_out) begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (in_tag.valid && en3) begin
            s3_m_reg     <= sel_m;
            s3_major_reg <= sel_major;
            s3_minor_reg <= sel_minor;
            s3_span_reg  <= sel_major - sel_minor;
            s3_a1_reg    <= sel_a1;
            s3_b1_reg    <= sel_b1;
            s3_a2_reg    <= sel_a2;
            s3_b2_reg    <= sel_b2;
            s3_row_reg   <= in_row;
            s3_col_reg   <= in_col;
        end
        if (s3_valid_reg && en4) begin
            s4_m_reg   <= s3_m_reg;
            s4_pm_reg  <= s3_m_reg * s3_major_reg;
            s4_pa1_reg <= s3_span_reg * s3_a1_reg;
            s4_pb1_reg <= s3_minor_reg * s3_b1_reg;
            s4_pa2_reg <= s3_span_reg * s3_a2_reg;
            s4_pb2_reg <= s3_minor_reg * s3_b2_reg;
            s4_row_reg <= s3_row_reg;
            s4_col_reg <= s3_col_reg;
        end
        if (s4_valid_reg && en_out) begin
            out_value_reg <= suppress ? '0 : s4_m_reg;
            out_row_reg   <= s4_row_reg;
            out_col_reg   <= s4_col_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_value = out_value_reg;
    assign res_row   = out_row_reg;
    assign res_col   = out_col_reg;

endmodule

[hdl/gradient_nonmax_suppression.sv]
// ----------------------------------------------------------------------------
// gradient_nonmax_suppression
// Streaming interpolated non-maximum suppression over a 3x3 magnitude window.
// ----------------------------------------------------------------------------
// Usage:
//   s_ carries one pixel per transaction in raster order: magnitude, gx, gy.
//   m_ carries one result per centre pixel, one row and one column behind the
//   input; pixels of the first row and column of the input give no result,
//   so the last row and column of the frame are never reported.
//   cfg_ writes image_width (index 0) or image_height (index 1); write only
//   while no pixel is in flight. Out-of-range values are clamped to [3, max].
//   Throughput: one pixel per cycle unless m_ stalls. The line memory holds
//   two magnitude rows and one gradient row in one word per column, read
//   and written back once per pixel, which sets that rate.
//   Path: the pixel that completes a window goes through front-end stages 1
//   and 2, decision stages 3 and 4 and the result register before m_.
//   Reset: position returns to row 0, column 0, the window clears and the
//   pipeline empties; line memory contents stay undefined until rewritten.
//   A stalled m_ holds its result; s_tready drops only once every stage
//   between the two sides is full.
// ----------------------------------------------------------------------------
module gradient_nonmax_suppression
    import gnms_pkg::*;
#(
    parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    localparam int COL_BITS   = $clog2(MAX_WIDTH),
    localparam int IN_TDATA_W = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((SAMPLE_BITS + ROW_BITS + COL_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // Pixel stream
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_TDATA_W-1:0]    s_tdata,   // grad_magnitude, grad_x, grad_y
    // Result stream
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_TDATA_W-1:0]   m_tdata    // thinned_value, result_row, result_col
);

    localparam int SB = SAMPLE_BITS;

    logic [CFG_W_BITS-1:0] width_cfg_reg;
    logic [CFG_H_BITS-1:0] height_cfg_reg;

    logic [SB-1:0]         in_mag;
    logic signed [SB-1:0]  in_gx;
    logic signed [SB-1:0]  in_gy;

    gnms_tag_t             ctr_tag;
    logic                  ctr_ready;
    logic [SB-1:0]         ctr_win [WIN_SIZE];
    logic signed [SB-1:0]  ctr_gx;
    logic signed [SB-1:0]  ctr_gy;
    logic [ROW_BITS-1:0]   ctr_row;
    logic [COL_BITS-1:0]   ctr_col;

    logic [SB-1:0]         res_value;
    logic [ROW_BITS-1:0]   res_row;
    logic [COL_BITS-1:0]   res_col;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= CFG_W_BITS'(WIDTH_RESET);
            height_cfg_reg <= CFG_H_BITS'(HEIGHT_RESET);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_cfg_reg  <= cfg_data[CFG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: height_cfg_reg <= cfg_data[CFG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Unpack the pixel
    assign in_mag = s_tdata[SB-1:0];
    assign in_gx  = s_tdata[2*SB-1:SB];
    assign in_gy  = s_tdata[3*SB-1:2*SB];

    gnms_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_width  (width_cfg_reg),
        .cfg_height (height_cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mag     (in_mag),
        .in_gx      (in_gx),
        .in_gy      (in_gy),
        .out_tag    (ctr_tag),
        .out_ready  (ctr_ready),
        .out_win    (ctr_win),
        .out_gx     (ctr_gx),
        .out_gy     (ctr_gy),
        .out_row    (ctr_row),
        .out_col    (ctr_col)
    );

    gnms_decide #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COL_BITS    (COL_BITS)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_tag    (ctr_tag),
        .in_ready  (ctr_ready),
        .in_win    (ctr_win),
        .in_gx     (ctr_gx),
        .in_gy     (ctr_gy),
        .in_row    (ctr_row),
        .in_col    (ctr_col),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_value (res_value),
        .res_row   (res_row),
        .res_col   (res_col)
    );

    // Pack the result, padded with zeros to whole bytes
    assign m_tdata = OUT_TDATA_W'({res_col, res_row, res_value});

endmodule

[hdl/gnms_checker.sv]
// ----------------------------------------------------------------------------
// gnms_assert_checker
// Port-level checks of the non-maximum suppression block, bound to the top.
// ----------------------------------------------------------------------------
`include "gradient_nonmax_suppression_defines.svh"

module gnms_assert_checker
    import gnms_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COL_BITS    = $clog2(DEF_MAX_WIDTH),
    parameter int OUT_TDATA_W = 40
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int SB = SAMPLE_BITS;

    logic [SB-1:0]       res_value;
    logic [ROW_BITS-1:0] res_row;
    logic [COL_BITS-1:0] res_col;

    assign res_value = m_tdata[SB-1:0];
    assign res_row   = m_tdata[SB+ROW_BITS-1:SB];
    assign res_col   = m_tdata[SB+ROW_BITS+COL_BITS-1:SB+ROW_BITS];

    // Hold a stalled result
    `GNMS_ASSERT_NEXT(a_res_hold, m_tvalid && !m_tready, m_tvalid)
    `GNMS_ASSERT_NEXT(a_res_stable, m_tvalid && !m_tready, $stable(m_tdata))

    // Empty the result register on reset
    `GNMS_ASSERT_RESET(a_reset_clears, !aresetn, !m_tvalid)

    // With nothing waiting at the output, the input side never stalls
    `GNMS_ASSERT_SAME(a_no_false_stall, !m_tvalid, s_tready)

    // Border centres always give zero
    `GNMS_ASSERT_SAME(a_border_zero, m_tvalid && (res_row == '0 || res_col == '0),
                      res_value == '0)

endmodule

bind gradient_nonmax_suppression gnms_assert_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COL_BITS    (COL_BITS),
    .OUT_TDATA_W (OUT_TDATA_W)
) u_gnms_checker (.*);

[tb/gnms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Non-maximum suppression result checker
// Watches the configuration, pixel and result channels and keeps its own
// line buffers, 3x3 window and raster position. For every accepted pixel it
// works out the thinned result, if any, and compares each accepted result
// field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module gnms_checker
    import gnms_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [47:0]              s_tdata,   // grad_magnitude, grad_x, grad_y
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [39:0]              m_tdata,   // thinned_value, result_row, result_col
    output int                       outstanding,
    output int                       mismatches
);

    localparam int MAX_COLS    = DEF_MAX_WIDTH;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [15:0]         value;
        logic [ROW_BITS-1:0] row;
        logic [9:0]          col;
    } thinned_t;

    // Shadow state of the block
    logic [CFG_W_BITS-1:0] width_reg;
    logic [CFG_H_BITS-1:0] height_reg;
    logic [15:0] mag_older [MAX_COLS];
    logic [15:0] mag_newer [MAX_COLS];
    logic [15:0] gx_row_buf [MAX_COLS];
    logic [15:0] gy_row_buf [MAX_COLS];
    logic [15:0] mag_win [WIN_SIZE];
    logic [15:0] gx_hold;
    logic [15:0] gy_hold;
    int          col_pos;
    int          row_pos;
    thinned_t    thinned_q [$];

    task automatic report_mismatch(string what, longint expected_v, longint got_v);
        if (mismatches < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what,
                     expected_v, got_v);
        mismatches++;
    endtask

    // True if m lies below the blend of a and b weighted by minor/major
    function automatic bit under_blend(longint unsigned m, longint unsigned major,
                                       longint unsigned minor, longint unsigned a,
                                       longint unsigned b);
        return m * major < (major - minor) * a + minor * b;
    endfunction

    // Keep the centre magnitude only if it peaks along the gradient direction
    function automatic logic [15:0] keep_if_peak(logic [15:0] centre,
                                                 logic signed [15:0] gx,
                                                 logic signed [15:0] gy);
        int              sx;
        int              sy;
        bit              x_major;
        int              a1;
        int              b1;
        int              a2;
        int              b2;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned major;
        longint unsigned minor;
        sx = gx;
        sy = gy;
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        if (centre == 0)
            return 16'd0;
        // Pick the octant and the two neighbour pairs to blend
        if (sx >= 0) begin
            if (sy >= 0) begin
                if (sx >= sy) begin
                    x_major = 1; a1 = WIN_E; b1 = WIN_SE; a2 = WIN_W; b2 = WIN_NW;
                end else begin
                    x_major = 0; a1 = WIN_S; b1 = WIN_SE; a2 = WIN_N; b2 = WIN_NW;
                end
            end else begin
                if (sx + sy >= 0) begin
                    x_major = 1; a1 = WIN_E; b1 = WIN_NE; a2 = WIN_W; b2 = WIN_SW;
                end else begin
                    x_major = 0; a1 = WIN_S; b1 = WIN_SW; a2 = WIN_N; b2 = WIN_NE;
                end
            end
        end else begin
            if (sy >= 0) begin
                if (sx + sy >= 0) begin
                    x_major = 0; a1 = WIN_S; b1 = WIN_SW; a2 = WIN_N; b2 = WIN_NE;
                end else begin
                    x_major = 1; a1 = WIN_W; b1 = WIN_SW; a2 = WIN_E; b2 = WIN_NE;
                end
            end else begin
                if (sy - sx >= 0) begin
                    x_major = 1; a1 = WIN_W; b1 = WIN_NW; a2 = WIN_E; b2 = WIN_SE;
                end else begin
                    x_major = 0; a1 = WIN_N; b1 = WIN_NW; a2 = WIN_S; b2 = WIN_SE;
                end
            end
        end
        major = x_major ? ax : ay;
        minor = x_major ? ay : ax;
        if (under_blend(centre, major, minor, mag_win[a1], mag_win[b1]) ||
            under_blend(centre, major, minor, mag_win[a2], mag_win[b2]))
            return 16'd0;
        return centre;
    endfunction

    // Advance the shadow state by one pixel and queue the result it causes
    task automatic thin_pixel(logic [47:0] px);
        int          w;
        int          h;
        int          c;
        int          r;
        logic [15:0] centre_gx;
        logic [15:0] centre_gy;
        thinned_t    res;
        w = width_reg;
        h = height_reg;
        if (w < MIN_DIM) w = MIN_DIM;
        if (w > MAX_COLS) w = MAX_COLS;
        if (h < MIN_DIM) h = MIN_DIM;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        c = col_pos;
        r = row_pos;

        // Slide the window left and bring in column c
        for (int k = 0; k < 3; k++) begin
            mag_win[k * 3]     = mag_win[k * 3 + 1];
            mag_win[k * 3 + 1] = mag_win[k * 3 + 2];
        end
        mag_win[WIN_NE] = mag_older[c];
        mag_win[WIN_E]  = mag_newer[c];
        mag_win[WIN_SE] = px[15:0];
        mag_older[c]    = mag_newer[c];
        mag_newer[c]    = px[15:0];

        // Centre gradient was fetched from the line one pixel earlier
        centre_gx     = gx_hold;
        centre_gy     = gy_hold;
        gx_hold       = gx_row_buf[c];
        gy_hold       = gy_row_buf[c];
        gx_row_buf[c] = px[31:16];
        gy_row_buf[c] = px[47:32];

        if (r >= 1 && c >= 1 && r < h && c < w) begin
            res.value = (r == 1 || c == 1) ? 16'd0 :
                        keep_if_peak(mag_win[WIN_C], centre_gx, centre_gy);
            res.row   = ROW_BITS'(r - 1);
            res.col   = 10'(c - 1);
            thinned_q.push_back(res);
        end

        // Raster position, wrapping also after a register shrank
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    task automatic check_result(logic [39:0] word);
        thinned_t exp_res;
        if (thinned_q.size() == 0) begin
            report_mismatch("unexpected result", -1, word[15:0]);
        end else begin
            exp_res = thinned_q.pop_front();
            if (word[15:0] !== exp_res.value)
                report_mismatch("thinned_value", exp_res.value, word[15:0]);
            if (word[27:16] !== exp_res.row)
                report_mismatch("result_row", exp_res.row, word[27:16]);
            if (word[37:28] !== exp_res.col)
                report_mismatch("result_col", exp_res.col, word[37:28]);
        end
    endtask

    initial mismatches = 0;
    initial outstanding = 0;

    // Follow every transaction on the three channels
    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            for (int i = 0; i < MAX_COLS; i++) begin
                mag_older[i]  = '0;
                mag_newer[i]  = '0;
                gx_row_buf[i] = '0;
                gy_row_buf[i] = '0;
            end
            for (int i = 0; i < WIN_SIZE; i++)
                mag_win[i] = '0;
            gx_hold = '0;
            gy_hold = '0;
            col_pos = 0;
            row_pos = 0;
            thinned_q.delete();
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  = cfg_data[CFG_W_BITS-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = cfg_data[CFG_H_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                thin_pixel(s_tdata);
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            outstanding <= thinned_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient non-maximum suppression testbench
// Drives raster pixels through a series of frame geometries: a directed frame
// over every octant and the field extremes, random small frames, the widest
// and tallest settings, clamped register values and registers shrunk in the
// middle of a frame. Both stream sides idle at random; a separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import gnms_pkg::*;

    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 900;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [47:0]              s_tdata;   // grad_magnitude, grad_x, grad_y
    logic                     m_tvalid;
    logic                     m_tready;
    logic [39:0]              m_tdata;   // thinned_value, result_row, result_col

    int outstanding;
    int mismatches;
    int cycle_count;
    int src_idle_pct;
    int sink_idle_pct;
    int probe_px [25][3];

    // Raster position as the block should see it, for finishing frames
    int pos_col;
    int pos_row;
    int frame_w;
    int frame_h;

    gradient_nonmax_suppression i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    gnms_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Stall the result side at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Give up on a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int clamp_dim(int v, int hi);
        return (v < MIN_DIM) ? MIN_DIM : (v > hi) ? hi : v;
    endfunction

    function automatic logic [47:0] pack_pixel(int mag, int gx, int gy);
        return {gy[15:0], gx[15:0], mag[15:0]};
    endfunction

    function automatic int extreme_grad();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return 32767;
            2:       return -1;
            3:       return 1;
            default: return 0;
        endcase
    endfunction

    // Mostly close magnitudes so that the blended compares go either way
    function automatic logic [47:0] random_pixel();
        int mag;
        int gx;
        int gy;
        case ($urandom_range(0, 9))
            0:          mag = 0;
            1:          mag = 65535;
            2, 3, 4:    mag = $urandom_range(1000, 1012);
            5:          mag = $urandom_range(0, 65535);
            default:    mag = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 7))
            0: begin
                gx = $urandom_range(0, 65535);
                gy = $urandom_range(0, 65535);
            end
            1: begin
                gx = extreme_grad();
                gy = extreme_grad();
            end
            2: begin
                // Octant boundaries on the diagonals
                gx = $urandom_range(0, 40) - 20;
                gy = $urandom_range(0, 1) ? gx : -gx;
            end
            3: begin
                gx = $urandom_range(0, 200) - 100;
                gy = 0;
                if ($urandom_range(0, 1)) begin
                    gy = gx;
                    gx = 0;
                end
            end
            default: begin
                gx = $urandom_range(0, 40) - 20;
                gy = $urandom_range(0, 40) - 20;
            end
        endcase
        return pack_pixel(mag, gx, gy);
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
            frame_w = clamp_dim(value & ((1 << CFG_W_BITS) - 1), DEF_MAX_WIDTH);
        else
            frame_h = clamp_dim(value & ((1 << CFG_H_BITS) - 1), MAX_HEIGHT);
        @(posedge aclk);
    endtask

    task automatic send_pixel(logic [47:0] px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        if (pos_col + 1 >= frame_w) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= frame_h) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    task automatic send_random(int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic finish_frame();
        while (pos_col != 0 || pos_row != 0)
            send_pixel(random_pixel());
    endtask

    // Hold the input idle until every expected result is out, then settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_frames(int budget);
        int sent;
        int w;
        int h;
        int n;
        sent = 0;
        while (sent < budget) begin
            w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
            h = $urandom_range(3, 7);
            n = w * h * $urandom_range(1, 2);
            write_reg(CFG_IMAGE_WIDTH, w);
            write_reg(CFG_IMAGE_HEIGHT, h);
            send_random(n);
            drain();
            sent += n;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_IMAGE_WIDTH;
        cfg_data    = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cycle_count = 0;
        pos_col     = 0;
        pos_row     = 0;
        frame_w     = WIDTH_RESET;
        frame_h     = HEIGHT_RESET;

        // 5x5 frame: border and zero cases outside; inner centres cover all eight octants and one zero gradient
        probe_px = '{
            '{100, 0, 0},      '{65535, 32767, -32768}, '{0, -32768, 32767},
            '{200, 5, 5},      '{50, 1, -1},
            '{300, 0, 0},      '{400, 10, 3},           '{400, 3, 10},
            '{400, 10, -3},    '{120, 0, 0},
            '{350, -1, 0},     '{500, 3, -10},          '{65535, -10, 3},
            '{400, -3, 10},    '{0, 0, 0},
            '{250, 0, -1},     '{400, -10, -3},         '{1, 0, 0},
            '{400, -3, -10},   '{65535, -32768, -32768},
            '{65535, 32767, 32767}, '{0, 0, 0},         '{7, -7, 7},
            '{123, 7, -7},     '{65535, -32768, 32767}
        };

        src_idle_pct  = 6;
        sink_idle_pct = 74;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_reg(CFG_IMAGE_WIDTH, 5);
        write_reg(CFG_IMAGE_HEIGHT, 5);
        for (int i = 0; i < 25; i++)
            send_pixel(pack_pixel(probe_px[i][0], probe_px[i][1], probe_px[i][2]));
        drain();
        random_frames(RANDOM_ITEMS / 3);

        src_idle_pct  = 74;
        sink_idle_pct = 6;
        random_frames(RANDOM_ITEMS / 3);

        // Tallest frame, then cut short below the current row
        write_reg(CFG_IMAGE_WIDTH, 3);
        write_reg(CFG_IMAGE_HEIGHT, MAX_HEIGHT);
        send_random(18);
        drain();
        write_reg(CFG_IMAGE_HEIGHT, 3);
        finish_frame();
        drain();

        // Narrow the line mid-row; upper data bits above the width are dropped
        write_reg(CFG_IMAGE_WIDTH, 12);
        write_reg(CFG_IMAGE_HEIGHT, 6);
        send_random(43);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 13'h1804);
        finish_frame();
        drain();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_frames(RANDOM_ITEMS / 3);

        // Out-of-range values saturate at both ends
        write_reg(CFG_IMAGE_WIDTH, 0);
        write_reg(CFG_IMAGE_HEIGHT, 0);
        send_random(9);
        drain();
        write_reg(CFG_IMAGE_WIDTH, 2047);
        write_reg(CFG_IMAGE_HEIGHT, 8191);
        send_random(40);
        drain();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/gnms_pkg.sv
hdl/gnms_line_ram.sv
hdl/gnms_front.sv
hdl/gnms_decide.sv
hdl/gradient_nonmax_suppression.sv
hdl/gnms_checker.sv
tb/gnms_checker.sv
tb/tb.sv
